// File: design/ctdst_pkg.sv
package ctdst_pkg;

	localparam int DEPTH_DEF  = 16;
	localparam int QDEPTH_DEF = 2;
	localparam int KEY_W      = 24;

	localparam logic [13:0] BAD_YEAR  = 14'd16383;
	localparam logic [3:0]  MONTH_MAX = 4'd12;
	localparam logic [4:0]  DAY_MAX   = 5'd31;

	typedef enum logic [1:0] {
		MODE_INSERT = 2'd0,
		MODE_DELETE = 2'd1,
		MODE_DUMP   = 2'd2,
		MODE_CLEAR  = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		STAT_DONE  = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2,
		STAT_DATA  = 2'd3
	} status_t;

	typedef struct packed {
		mode_t       mode;
		logic        kind;
		logic [13:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [15:0] entry_id;
	} req_t;

	typedef struct packed {
		status_t     status;
		logic        out_kind;
		logic [13:0] out_year;
		logic [3:0]  out_month;
		logic [4:0]  out_day;
		logic [15:0] out_id;
		logic [4:0]  removed;
		logic        last;
	} rsp_t;

	typedef struct packed {
		logic        kind;
		logic [13:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [15:0] id;
	} entry_t;

	typedef struct packed {
		mode_t  mode;
		entry_t entry;
	} cmd_t;

	// Sort order: class first, then the stored date.
	function automatic logic [KEY_W-1:0] entry_key(entry_t e);
		return {e.kind, e.year, e.month, e.day};
	endfunction

endpackage

// File: design/ctdst_front.sv
module ctdst_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  ctdst_pkg::req_t req,
	output logic           cmd_valid,
	input  logic           cmd_ready,
	output ctdst_pkg::cmd_t cmd
);
	import ctdst_pkg::*;

	cmd_t cmd_d;
	cmd_t cmd_s1;
	logic vld_s1;
	logic bad_date;

	always_comb begin
		bad_date = (req.month == 4'd0) || (req.month > MONTH_MAX) ||
			(req.day == 5'd0) || (req.day > DAY_MAX) || (req.year == 14'd0);
		cmd_d.mode        = req.mode;
		cmd_d.entry.kind  = req.kind;
		cmd_d.entry.year  = req.year;
		cmd_d.entry.month = req.month;
		cmd_d.entry.day   = req.day;
		cmd_d.entry.id    = req.entry_id;
		// An invalid date is stored as year BAD_YEAR, day 0, month kept.
		if (bad_date) begin
			cmd_d.entry.year = BAD_YEAR;
			cmd_d.entry.day  = 5'd0;
		end
	end

	assign req_ready = !vld_s1 || cmd_ready;
	assign cmd_valid = vld_s1;
	assign cmd       = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (req_ready) begin
			vld_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			cmd_s1 <= cmd_d;
		end
	end

endmodule

// File: design/ctdst_queue.sv
module ctdst_queue #(
	parameter int QDEPTH = ctdst_pkg::QDEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  ctdst_pkg::cmd_t in_cmd,
	output logic           out_valid,
	input  logic           out_ready,
	output ctdst_pkg::cmd_t out_cmd
);
	import ctdst_pkg::*;

	localparam int PTR_W = $clog2(QDEPTH);
	localparam int CNT_W = $clog2(QDEPTH + 1);

	cmd_t             slot_q [QDEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign in_ready  = count_q != CNT_W'(QDEPTH);
	assign out_valid = count_q != '0;
	assign out_cmd   = slot_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= in_cmd;
		end
	end

endmodule

// File: design/ctdst_back.sv
module ctdst_back #(
	parameter int DEPTH = ctdst_pkg::DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_ready,
	input  ctdst_pkg::cmd_t cmd,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output ctdst_pkg::rsp_t rsp
);
	import ctdst_pkg::*;

	localparam int CNT_W = $clog2(DEPTH + 1);

	typedef enum logic [1:0] {
		ST_IDLE  = 2'b01,
		ST_SWEEP = 2'b10
	} state_t;

	state_t           state_q;
	entry_t           cell_q [DEPTH];
	logic [CNT_W-1:0] occ_q;
	logic [CNT_W-1:0] remain_q;
	logic [CNT_W-1:0] gone_q;
	logic [CNT_W-1:0] gone_nxt;
	logic [CNT_W+4:0] gone_ext;
	logic             dump_q;
	logic [15:0]      del_id_q;
	logic             rsp_valid_q;
	rsp_t             rsp_q;
	rsp_t             rsp_d;
	logic             rsp_load;

	logic             out_free;
	logic             take;
	logic             step;
	logic             full;
	logic             empty;
	logic             do_ins;
	logic             keep;
	entry_t           head;
	logic [KEY_W-1:0] new_key;
	logic [DEPTH-1:0] le;

	assign out_free  = !rsp_valid_q || rsp_ready;
	assign cmd_ready = (state_q == ST_IDLE) && out_free;
	assign take      = cmd_valid && cmd_ready;
	assign step      = (state_q == ST_SWEEP) && out_free;
	assign full      = occ_q == CNT_W'(DEPTH);
	assign empty     = occ_q == '0;
	assign do_ins    = take && (cmd.mode == MODE_INSERT) && !full;
	assign head      = cell_q[0];
	assign keep      = dump_q || (head.id != del_id_q);
	assign new_key   = entry_key(cmd.entry);
	assign gone_nxt  = gone_q + CNT_W'(!keep);
	assign gone_ext  = {5'd0, gone_nxt};
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Each cell either holds, takes the new word, or takes its lower neighbor
	// on insert; a sweep rotates the row one place toward cell 0, and the
	// head goes back in at the tail unless a delete drops it.
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		entry_t below_w;
		entry_t above_w;
		logic   prev_le_w;
		logic   tail_w;

		assign le[g]  = (CNT_W'(g) < occ_q) && (entry_key(cell_q[g]) <= new_key);
		assign tail_w = CNT_W'(g + 1) == occ_q;

		if (g == 0) begin : g_first
			assign below_w   = cmd.entry;
			assign prev_le_w = 1'b1;
		end else begin : g_rest
			assign below_w   = cell_q[g-1];
			assign prev_le_w = le[g-1];
		end

		if (g == DEPTH - 1) begin : g_end
			assign above_w = cell_q[g];
		end else begin : g_mid
			assign above_w = cell_q[g+1];
		end

		always_ff @(posedge clk) begin
			if (do_ins) begin
				if (!le[g]) begin
					cell_q[g] <= prev_le_w ? cmd.entry : below_w;
				end
			end else if (step) begin
				cell_q[g] <= (keep && tail_w) ? head : above_w;
			end
		end
	end

	always_comb begin
		rsp_load      = 1'b0;
		rsp_d         = '0;
		rsp_d.status  = STAT_DONE;
		rsp_d.last    = 1'b1;
		if (take) begin
			case (cmd.mode)
				MODE_INSERT: begin
					rsp_load     = 1'b1;
					rsp_d.status = full ? STAT_FULL : STAT_DONE;
				end
				MODE_DELETE: begin
					rsp_load = empty;
				end
				MODE_DUMP: begin
					rsp_load     = empty;
					rsp_d.status = STAT_EMPTY;
				end
				MODE_CLEAR: begin
					rsp_load = 1'b1;
				end
				default: begin
					rsp_load = 1'b0;
				end
			endcase
		end else if (step) begin
			if (dump_q) begin
				rsp_load        = 1'b1;
				rsp_d.status    = STAT_DATA;
				rsp_d.out_kind  = head.kind;
				rsp_d.out_year  = head.year;
				rsp_d.out_month = head.month;
				rsp_d.out_day   = head.day;
				rsp_d.out_id    = head.id;
				rsp_d.last      = remain_q == CNT_W'(1);
			end else if (remain_q == CNT_W'(1)) begin
				rsp_load      = 1'b1;
				rsp_d.removed = gone_ext[4:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			occ_q       <= '0;
			remain_q    <= '0;
			gone_q      <= '0;
			dump_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (take) begin
				case (cmd.mode)
					MODE_INSERT: begin
						if (!full) begin
							occ_q <= occ_q + 1'b1;
						end
					end
					MODE_DELETE: begin
						if (!empty) begin
							state_q  <= ST_SWEEP;
							dump_q   <= 1'b0;
							remain_q <= occ_q;
							gone_q   <= '0;
						end
					end
					MODE_DUMP: begin
						if (!empty) begin
							state_q  <= ST_SWEEP;
							dump_q   <= 1'b1;
							remain_q <= occ_q;
						end
					end
					MODE_CLEAR: begin
						occ_q <= '0;
					end
					default: begin
						occ_q <= occ_q;
					end
				endcase
			end else if (step) begin
				remain_q <= remain_q - 1'b1;
				if (!keep) begin
					occ_q  <= occ_q - 1'b1;
					gone_q <= gone_nxt;
				end
				if (remain_q == CNT_W'(1)) begin
					state_q <= ST_IDLE;
				end
			end

			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && cmd.mode == MODE_DELETE) begin
			del_id_q <= cmd.entry.id;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q <= rsp_d;
		end
	end

endmodule

// File: design/class_then_date_sorted_table.sv
// Sorted table of up to DEPTH dated entries, first-class entries ahead of
// second-class ones and each class in ascending date order, with ties placed
// after equal entries. The table is empty after reset. A front stage checks
// and normalizes each request word and passes it through a QDEPTH-entry queue
// to the table unit, which works on one request at a time. In the table unit
// an insert, a clear, a full-table insert and a delete or dump of an empty
// table finish as the request is taken; a delete or a dump of an occupied
// table starts a sweep past every stored entry, since the cell row rotates
// one place per cycle past its head while the response word can move. A dump
// emits one entry word per cycle while the response side is ready, and any
// cycle in which the response word cannot move stalls the rotation. A request
// passes the front register and then the queue before the table unit sees it.
module class_then_date_sorted_table_core #(
	parameter int DEPTH  = ctdst_pkg::DEPTH_DEF,
	parameter int QDEPTH = ctdst_pkg::QDEPTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  ctdst_pkg::req_t req,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output ctdst_pkg::rsp_t rsp
);
	import ctdst_pkg::*;

	cmd_t f_cmd;
	logic f_valid;
	logic f_ready;
	cmd_t q_cmd;
	logic q_valid;
	logic q_ready;

	ctdst_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.cmd_valid (f_valid),
		.cmd_ready (f_ready),
		.cmd       (f_cmd)
	);

	ctdst_queue #(
		.QDEPTH (QDEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.in_cmd    (f_cmd),
		.out_valid (q_valid),
		.out_ready (q_ready),
		.out_cmd   (q_cmd)
	);

	ctdst_back #(
		.DEPTH (DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (q_valid),
		.cmd_ready (q_ready),
		.cmd       (q_cmd),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

// File: design/ctdst_checker.sv
module ctdst_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            req_valid,
	input logic            req_ready,
	input ctdst_pkg::req_t req,
	input logic            rsp_valid,
	input logic            rsp_ready,
	input ctdst_pkg::rsp_t rsp
);
	import ctdst_pkg::*;

	// A word that is not entry data ends its request and carries no entry.
	a_nondata_word: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != STAT_DATA |->
		rsp.last && rsp.out_kind == 1'b0 && rsp.out_year == 14'd0 &&
		rsp.out_month == 4'd0 && rsp.out_day == 5'd0 && rsp.out_id == 16'd0)
		else $error("non-data word carries entry fields or lacks last");

	// Only a delete's word can report removed entries.
	a_removed_done: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.removed != 5'd0 |-> rsp.status == STAT_DONE)
		else $error("removed count on a word that is not a delete result");

	// Stored dates are either real (day at least 1) or the invalid marker.
	a_stored_date: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == STAT_DATA && rsp.out_day == 5'd0 |->
		rsp.out_year == BAD_YEAR)
		else $error("dumped entry with day zero but a real year");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response word changed or dropped while stalled");

	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_ready |=> req_valid && $stable(req))
		else $error("request word changed or dropped while stalled");

endmodule

bind class_then_date_sorted_table_core ctdst_checker u_ctdst_checker (.*);

// File: tb/class_then_date_sorted_table_core_tb.sv
`timescale 1ns / 1ps

module class_then_date_sorted_table_core_tb;
	import ctdst_pkg::*;

	localparam int TABLE_DEPTH = DEPTH_DEF;
	localparam int RANDOM_WORDS = 176;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	// Shadow copy of the table, updated as each request word is accepted.
	entry_t table_rows [TABLE_DEPTH];
	int row_count = 0;
	rsp_t expected_rsp [$];

	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	int error_count = 0;
	int rsp_index = 0;

	class_then_date_sorted_table_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		#4_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		$display("ERROR at %0t: response %0d: %s", $realtime, rsp_index, msg);
		error_count++;
	endtask

	task automatic check_field(input string name, input logic [15:0] got,
			input logic [15:0] want);
		if (got !== want) begin
			report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
		end
	endtask

	// Works out the response words for one accepted request word.
	function automatic void table_apply(input req_t w);
		entry_t e;
		rsp_t r;
		int pos;
		int gone;
		int keep;
		int i;
		r = '0;
		r.status = STAT_DONE;
		r.last = 1'b1;
		case (w.mode)
			MODE_INSERT: begin
				e.kind = w.kind;
				e.year = w.year;
				e.month = w.month;
				e.day = w.day;
				e.id = w.entry_id;
				if (w.month < 4'd1 || w.month > MONTH_MAX || w.day < 5'd1 ||
						w.day > DAY_MAX || w.year == '0) begin
					e.year = BAD_YEAR;
					e.day = '0;
				end
				if (row_count >= TABLE_DEPTH) begin
					r.status = STAT_FULL;
				end else begin
					// A tie goes after the entries it equals.
					pos = 0;
					while (pos < row_count &&
							{table_rows[pos].kind, table_rows[pos].year,
							table_rows[pos].month, table_rows[pos].day} <=
							{e.kind, e.year, e.month, e.day})
						pos++;
					for (i = row_count; i > pos; i--)
						table_rows[i] = table_rows[i - 1];
					table_rows[pos] = e;
					row_count++;
				end
				expected_rsp.push_back(r);
			end
			MODE_DELETE: begin
				keep = 0;
				gone = 0;
				for (i = 0; i < row_count; i++) begin
					if (table_rows[i].id == w.entry_id) begin
						gone++;
					end else begin
						table_rows[keep] = table_rows[i];
						keep++;
					end
				end
				row_count = keep;
				r.removed = gone[4:0];
				expected_rsp.push_back(r);
			end
			MODE_DUMP: begin
				if (row_count == 0) begin
					r.status = STAT_EMPTY;
					expected_rsp.push_back(r);
				end else begin
					for (i = 0; i < row_count; i++) begin
						r = '0;
						r.status = STAT_DATA;
						r.out_kind = table_rows[i].kind;
						r.out_year = table_rows[i].year;
						r.out_month = table_rows[i].month;
						r.out_day = table_rows[i].day;
						r.out_id = table_rows[i].id;
						r.last = (i == row_count - 1);
						expected_rsp.push_back(r);
					end
				end
			end
			default: begin
				row_count = 0;
				expected_rsp.push_back(r);
			end
		endcase
	endfunction

	// Response side: random stalls, and each accepted word is checked.
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (expected_rsp.size() == 0) begin
				report_mismatch($sformatf("unexpected response word %0h", rsp));
			end else begin
				want = expected_rsp.pop_front();
				check_field("status", 16'(rsp.status), 16'(want.status));
				check_field("out_kind", 16'(rsp.out_kind), 16'(want.out_kind));
				check_field("out_year", 16'(rsp.out_year), 16'(want.out_year));
				check_field("out_month", 16'(rsp.out_month), 16'(want.out_month));
				check_field("out_day", 16'(rsp.out_day), 16'(want.out_day));
				check_field("out_id", rsp.out_id, want.out_id);
				check_field("removed", 16'(rsp.removed), 16'(want.removed));
				check_field("last", 16'(rsp.last), 16'(want.last));
			end
			rsp_index++;
		end
		rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	task automatic send_word(input req_t w);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req <= w;
		req_valid <= 1'b1;
		do
			@(posedge clk);
		while (!req_ready);
		table_apply(w);
	endtask

	// Holds the request side off until every expected word has come back.
	task automatic drain;
		req_valid <= 1'b0;
		while (expected_rsp.size() != 0)
			@(posedge clk);
	endtask

	function automatic req_t make_word(input mode_t m, input logic k,
			input logic [13:0] y, input logic [3:0] mo, input logic [4:0] d,
			input logic [15:0] id);
		req_t w;
		w.mode = m;
		w.kind = k;
		w.year = y;
		w.month = mo;
		w.day = d;
		w.entry_id = id;
		return w;
	endfunction

	function automatic req_t random_word;
		req_t w;
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 55)
			w.mode = MODE_INSERT;
		else if (pick < 72)
			w.mode = MODE_DELETE;
		else if (pick < 96)
			w.mode = MODE_DUMP;
		else
			w.mode = MODE_CLEAR;
		w.kind = 1'($urandom_range(1));
		// Few distinct dates and ids, so that ties and repeated deletes are common.
		case ($urandom_range(9))
			0: w.year = '0;
			1: w.year = 14'($urandom_range(16383));
			default: w.year = 14'($urandom_range(2024, 2021));
		endcase
		w.month = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) :
			4'($urandom_range(12, 1));
		w.day = ($urandom_range(9) == 0) ? 5'($urandom_range(31)) :
			(($urandom_range(1) == 0) ? 5'($urandom_range(3, 1)) :
			5'($urandom_range(31, 1)));
		w.entry_id = ($urandom_range(3) == 0) ? 16'($urandom_range(16'hFFFF)) :
			16'($urandom_range(15));
		return w;
	endfunction

	task automatic test_empty_table;
		send_word(make_word(MODE_DUMP, 1'b0, '0, '0, '0, '0));
		send_word(make_word(MODE_DELETE, 1'b1, '1, '1, '1, 16'hFFFF));
		drain();
	endtask

	task automatic test_ordering_and_dates;
		send_word(make_word(MODE_INSERT, 1'b0, 14'd2000, 4'd6, 5'd15, 16'd1));
		send_word(make_word(MODE_INSERT, 1'b1, 14'd9999, 4'd12, 5'd31, 16'hFFFF));
		send_word(make_word(MODE_INSERT, 1'b0, 14'd1, 4'd1, 5'd1, 16'd0));
		send_word(make_word(MODE_INSERT, 1'b0, 14'd2010, 4'd0, 5'd10, 16'd1));
		send_word(make_word(MODE_INSERT, 1'b1, 14'd2010, 4'd15, 5'd10, 16'd2));
		send_word(make_word(MODE_INSERT, 1'b0, 14'd2010, 4'd3, 5'd0, 16'd3));
		send_word(make_word(MODE_INSERT, 1'b0, 14'd0, 4'd3, 5'd3, 16'd1));
		// A valid date in the sentinel year is kept as given.
		send_word(make_word(MODE_INSERT, 1'b0, 14'd16383, 4'd12, 5'd31, 16'd4));
		send_word(make_word(MODE_INSERT, 1'b0, 14'd2000, 4'd6, 5'd15, 16'd5));
		send_word(make_word(MODE_INSERT, 1'b1, 14'd9999, 4'd12, 5'd31, 16'd6));
		drain();
	endtask

	task automatic test_full_table;
		req_t w;
		while (row_count < TABLE_DEPTH) begin
			w = random_word();
			w.mode = MODE_INSERT;
			w.entry_id = 16'(7 + row_count);
			send_word(w);
		end
		send_word(make_word(MODE_INSERT, 1'b0, 14'd1999, 4'd1, 5'd1, 16'd99));
		send_word(make_word(MODE_DUMP, 1'b0, '0, '0, '0, '0));
		send_word(make_word(MODE_DELETE, 1'b0, '0, '0, '0, 16'd1));
		send_word(make_word(MODE_DELETE, 1'b0, '0, '0, '0, 16'h7777));
		send_word(make_word(MODE_DUMP, 1'b1, '1, '1, '1, '1));
		send_word(make_word(MODE_CLEAR, 1'b1, '1, '1, '1, 16'hFFFF));
		send_word(make_word(MODE_DUMP, 1'b0, '0, '0, '0, '0));
		drain();
	endtask

	task automatic test_random_traffic(input int count, input int unsigned send_pct,
			input int unsigned recv_pct);
		int n;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		for (n = 0; n < count; n++) begin
			send_word(random_word());
			if ($urandom_range(49) == 0)
				drain();
		end
		drain();
	endtask

	initial begin
		send_idle_pct = 30;
		recv_idle_pct = 80;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_table();
		test_ordering_and_dates();
		test_full_table();
		test_random_traffic(RANDOM_WORDS / 3, 30, 80);
		test_random_traffic(RANDOM_WORDS / 3, 80, 30);
		test_random_traffic(RANDOM_WORDS - 2 * (RANDOM_WORDS / 3), 0, 0);
		drain();
		// Leave room for any stray response word to show up.
		repeat (4 * TABLE_DEPTH) @(posedge clk);
		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

// File: files.f
design/ctdst_pkg.sv
design/ctdst_front.sv
design/ctdst_queue.sv
design/ctdst_back.sv
design/class_then_date_sorted_table.sv
design/ctdst_checker.sv
tb/class_then_date_sorted_table_core_tb.sv
